/* rtl/core/clutd_pkg.sv */
// Shared types, constants and helpers for the palette image decoder.
package clutd_pkg;

	localparam int DEF_MAX_WIDTH  = 640;
	localparam int DEF_MAX_HEIGHT = 512;

	localparam int POS_W     = 33;   // file offset, saturating, wide enough for 8 + 32-bit size
	localparam int COLOR_W   = 15;
	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW    = 8;

	localparam logic [31:0] MAGIC_WORD = 32'h10;
	localparam logic [31:0] MODE_4BPP  = 32'd8;
	localparam logic [31:0] MODE_8BPP  = 32'd9;

	localparam logic [15:0] COLORS_4BPP = 16'd16;
	localparam logic [15:0] COLORS_8BPP = 16'd256;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CLUT,
		PH_IMGHDR,
		PH_PIXELS,
		PH_TAIL,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_FORMAT  = 3'd1,
		ST_BAD_PALETTE = 3'd2,
		ST_BAD_IMAGE   = 3'd3,
		ST_BAD_SIZE    = 3'd4,
		ST_TRUNCATED   = 3'd5
	} status_t;

	// 5-bit channel to 8 bits by bit replication
	function automatic logic [7:0] expand5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

endpackage

/* rtl/core/clut_image_to_rgb_decoder.sv */
// Top level: palette image byte stream parser and RGB888 pixel expander.
//
// Input channel: one file byte per transfer (data_byte, end_of_file on the
// last byte), little-endian fields. Output channel: one result item per
// transfer: a pixel (status ok, closing 0) or the single closing status of
// the file (ok, bad format/palette/image block/size, or truncated).
//
// The items a byte produces are registered and appear on the output in the
// cycle after the byte's transfer. The input takes one byte per cycle while
// each byte makes at most one item and the receiver does not stall. A
// 4-bit-mode pixel byte makes two pixels, a byte that also closes the file
// adds one more item, and the input waits until a byte's last item goes out.
// The bound is the single output register stage, one item per unstalled cycle.
//
// The palette lives in a 256 x 15 RAM with two read ports (one per nibble);
// its read address is held while the output stalls so the read data stays
// put. Palette writes finish long before the first pixel byte arrives.
//
// Reset clears the parser phase, offset and mode and the pending items; the
// payload registers and palette RAM are not cleared. While the receiver stalls,
// the pending items hold and the input stays stalled.
module clut_image_to_rgb_decoder #(
	parameter int MAX_WIDTH  = clutd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = clutd_pkg::DEF_MAX_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_file,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [9:0] width,
	output logic [9:0] height,
	output logic       closing
);

	localparam int IW = $clog2(MAX_WIDTH + 1);
	localparam int IH = $clog2(MAX_HEIGHT + 1);
	localparam int PW = clutd_pkg::POS_W;
	localparam int AW = clutd_pkg::PAL_AW;
	localparam int CW = clutd_pkg::COLOR_W;

	// ---------------- parser state ----------------
	clutd_pkg::phase_t phase_q, phase_nx;
	logic [PW-1:0] pos_q;          // byte offset in file, or within image block
	logic [23:0]   acc_q;          // last three bytes, newest in the top byte
	logic          four_q;
	logic [PW-1:0] clut_end_q;     // 8 + palette block size
	logic [15:0]   cw_q;           // palette width
	logic          cc_nz_q;        // palette count nonzero
	logic [31:0]   ibs_q;          // image block size
	logic [15:0]   rw_q;           // words per row
	logic [IW-1:0] img_w_q;
	logic [IH-1:0] img_h_q;
	logic [IW-1:0] col_q;          // byte within row
	logic [IH-1:0] row_q;

	// ---------------- output stage ----------------
	logic [2:0]          pend_q;   // {status, pixel1, pixel0} still to send
	clutd_pkg::status_t  code_s1;
	logic                show_s1;  // status carries width/height
	logic [IW-1:0]       w_s1;
	logic [IH-1:0]       h_s1;
	logic [AW-1:0]       idx0_s1, idx1_s1;

	logic acc, out_xfer, last_out;
	logic [2:0] pend_nx;

	// ---------------- decode ----------------
	logic [31:0]   word;
	logic [PW-1:0] pos_nx;
	logic [PW-1:0] hdr_end, clut_end_eff, pal_min_end;
	logic [15:0]   colors;
	logic          clut_done, clut_bad, tail_done;
	logic [31:0]   ibs_eff;
	logic [16:0]   rb;
	logic [17:0]   w18;
	logic [15:0]   h16;
	logic [32:0]   prod, lim;
	logic          size_bad;
	logic [IW-1:0] col_nx;
	logic [IH-1:0] row_nx;
	logic          last_col, pix_done;

	// actions of the current byte
	logic               ev_fail, ev_ok, go_clut, go_img, go_pix, go_tail, pix_v, trunc;
	clutd_pkg::status_t ev_code;

	// palette RAM
	logic          ram_we;
	logic [AW-1:0] ram_waddr, raddr0, raddr1, idx0_nx, idx1_nx;
	logic [9:0]    pal_off;
	logic [CW-1:0] rdata0, rdata1;

	assign word         = {data_byte, acc_q};
	assign pos_nx       = (&pos_q) ? pos_q : pos_q + 1'b1;
	assign hdr_end      = PW'(word) + PW'(8);
	assign clut_end_eff = (phase_q == clutd_pkg::PH_HEADER) ? hdr_end : clut_end_q;
	assign colors       = four_q ? clutd_pkg::COLORS_4BPP : clutd_pkg::COLORS_8BPP;
	assign pal_min_end  = PW'(20) + PW'({colors, 1'b0});
	assign clut_done    = pos_nx >= clut_end_eff;
	assign clut_bad     = (clut_end_eff < pal_min_end) || (cw_q < colors) || !cc_nz_q;
	assign tail_done    = pos_nx >= PW'(ibs_q);
	assign ibs_eff      = (pos_q == PW'(3)) ? word : ibs_q;

	// image size check, made at the last image header byte
	assign rb       = {rw_q, 1'b0};
	assign w18      = four_q ? {rb, 1'b0} : {1'b0, rb};
	assign h16      = word[31:16];
	assign prod     = 33'(rb) * 33'(h16);
	assign lim      = 33'(ibs_q) - 33'd12;
	assign size_bad = (w18 == '0) || (w18 > 18'(MAX_WIDTH)) || (h16 == '0) ||
	                  (h16 > 16'(MAX_HEIGHT)) || (prod > lim);

	// pixel bytes walk rows of rb bytes; a row is a whole number of bytes
	assign col_nx   = col_q + 1'b1;
	assign row_nx   = row_q + 1'b1;
	assign last_col = col_nx == IW'(rb);
	assign pix_done = last_col && (row_nx == img_h_q);

	// ---------------- handshake ----------------
	assign out_valid = |pend_q;
	assign out_xfer  = out_valid && !out_stall;
	assign pend_nx   = pend_q & (pend_q - 3'd1);
	assign last_out  = pend_nx == '0;
	assign in_stall  = out_valid && !(out_xfer && last_out);
	assign acc       = in_valid && !in_stall;

	// ---------------- actions ----------------
	always_comb begin
		ev_fail = 1'b0;
		ev_ok   = 1'b0;
		ev_code = clutd_pkg::ST_OK;
		go_clut = 1'b0;
		go_img  = 1'b0;
		go_pix  = 1'b0;
		go_tail = 1'b0;
		pix_v   = 1'b0;
		unique case (phase_q)
			clutd_pkg::PH_HEADER: begin
				if (pos_q == PW'(3) && word != clutd_pkg::MAGIC_WORD) begin
					ev_fail = 1'b1;
					ev_code = clutd_pkg::ST_BAD_FORMAT;
				end else if (pos_q == PW'(7) && word != clutd_pkg::MODE_4BPP &&
				             word != clutd_pkg::MODE_8BPP) begin
					ev_fail = 1'b1;
					ev_code = clutd_pkg::ST_BAD_FORMAT;
				end else if (pos_q == PW'(11)) begin
					if (!clut_done) begin
						go_clut = 1'b1;
					end else if (clut_bad) begin
						ev_fail = 1'b1;
						ev_code = clutd_pkg::ST_BAD_PALETTE;
					end else begin
						go_img = 1'b1;
					end
				end
			end
			clutd_pkg::PH_CLUT: begin
				if (clut_done) begin
					if (clut_bad) begin
						ev_fail = 1'b1;
						ev_code = clutd_pkg::ST_BAD_PALETTE;
					end else begin
						go_img = 1'b1;
					end
				end
			end
			clutd_pkg::PH_IMGHDR: begin
				if (pos_q >= PW'(3) && ibs_eff < 32'd12 && pos_nx >= PW'(ibs_eff)) begin
					ev_fail = 1'b1;
					ev_code = clutd_pkg::ST_BAD_IMAGE;
				end else if (pos_q == PW'(11)) begin
					if (size_bad) begin
						ev_fail = 1'b1;
						ev_code = clutd_pkg::ST_BAD_SIZE;
					end else begin
						go_pix = 1'b1;
					end
				end
			end
			clutd_pkg::PH_PIXELS: begin
				pix_v = 1'b1;
				if (pix_done) begin
					if (tail_done) begin
						ev_ok = 1'b1;
					end else begin
						go_tail = 1'b1;
					end
				end
			end
			clutd_pkg::PH_TAIL: begin
				if (tail_done) begin
					ev_ok = 1'b1;
				end
			end
			clutd_pkg::PH_DONE: begin
			end
			default: begin
			end
		endcase
		trunc = end_of_file && !ev_fail && !ev_ok && phase_q != clutd_pkg::PH_DONE;
	end

	// ---------------- next phase ----------------
	always_comb begin
		phase_nx = phase_q;
		if (acc) begin
			if (end_of_file) begin
				phase_nx = clutd_pkg::PH_HEADER;
			end else if (ev_fail || ev_ok) begin
				phase_nx = clutd_pkg::PH_DONE;
			end else if (go_clut) begin
				phase_nx = clutd_pkg::PH_CLUT;
			end else if (go_img) begin
				phase_nx = clutd_pkg::PH_IMGHDR;
			end else if (go_pix) begin
				phase_nx = clutd_pkg::PH_PIXELS;
			end else if (go_tail) begin
				phase_nx = clutd_pkg::PH_TAIL;
			end
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= clutd_pkg::PH_HEADER;
			pos_q   <= '0;
			four_q  <= 1'b0;
			pend_q  <= '0;
		end else begin
			phase_q <= phase_nx;
			if (acc) begin
				if (end_of_file || go_img) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_nx;
				end
				if (end_of_file) begin
					four_q <= 1'b0;
				end else if (phase_q == clutd_pkg::PH_HEADER && pos_q == PW'(7)) begin
					if (word == clutd_pkg::MODE_4BPP) begin
						four_q <= 1'b1;
					end else if (word == clutd_pkg::MODE_8BPP) begin
						four_q <= 1'b0;
					end
				end
				pend_q <= {ev_fail || ev_ok || trunc, pix_v && four_q, pix_v};
			end else if (out_xfer) begin
				pend_q <= pend_nx;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (acc) begin
			acc_q <= {data_byte, acc_q[23:8]};
			if (phase_q == clutd_pkg::PH_HEADER && pos_q == PW'(11)) begin
				clut_end_q <= hdr_end;
			end
			if (phase_q == clutd_pkg::PH_CLUT && pos_q == PW'(17)) begin
				cw_q <= word[31:16];
			end
			if (phase_q == clutd_pkg::PH_CLUT && pos_q == PW'(19)) begin
				cc_nz_q <= |word[31:16];
			end
			if (phase_q == clutd_pkg::PH_IMGHDR && pos_q == PW'(3)) begin
				ibs_q <= word;
			end
			if (phase_q == clutd_pkg::PH_IMGHDR && pos_q == PW'(9)) begin
				rw_q <= word[31:16];
			end
			if (go_pix) begin
				img_w_q <= IW'(w18);
				img_h_q <= IH'(h16);
				col_q   <= '0;
				row_q   <= '0;
			end else if (phase_q == clutd_pkg::PH_PIXELS) begin
				col_q <= last_col ? '0 : col_nx;
				if (last_col) begin
					row_q <= row_nx;
				end
			end
			code_s1 <= trunc ? clutd_pkg::ST_TRUNCATED : ev_code;
			show_s1 <= ev_ok;
			w_s1    <= img_w_q;
			h_s1    <= img_h_q;
			idx0_s1 <= idx0_nx;
			idx1_s1 <= idx1_nx;
		end
	end

	// ---------------- palette RAM ----------------
	assign pal_off   = pos_q[9:0] - 10'd20;
	assign ram_we    = acc && phase_q == clutd_pkg::PH_CLUT && pos_q[0] &&
	                   pos_q >= PW'(20) && pos_q < pal_min_end;
	assign ram_waddr = pal_off[AW:1];
	assign idx0_nx   = four_q ? {4'b0, data_byte[3:0]} : data_byte;
	assign idx1_nx   = {4'b0, data_byte[7:4]};
	// hold the address while the items wait, so read data stays stable
	assign raddr0    = acc ? idx0_nx : idx0_s1;
	assign raddr1    = acc ? idx1_nx : idx1_s1;

	clutd_ram #(
		.WIDTH(CW),
		.DEPTH(clutd_pkg::PAL_DEPTH)
	) u_pal (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({data_byte[6:0], acc_q[23:16]}),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	// ---------------- output mux ----------------
	logic          cur_p0, cur_p1, cur_st, shown;
	logic [CW-1:0] color;

	assign cur_p0  = pend_q[0];
	assign cur_p1  = !pend_q[0] && pend_q[1];
	assign cur_st  = pend_q == 3'b100;
	assign color   = cur_p0 ? rdata0 : (cur_p1 ? rdata1 : '0);
	assign shown   = !cur_st || show_s1;
	assign status  = cur_st ? code_s1 : clutd_pkg::ST_OK;
	assign red     = clutd_pkg::expand5(color[4:0]);
	assign green   = clutd_pkg::expand5(color[9:5]);
	assign blue    = clutd_pkg::expand5(color[14:10]);
	assign width   = shown ? 10'(w_s1) : '0;
	assign height  = shown ? 10'(h_s1) : '0;
	assign closing = cur_st;

	// ---------------- assertions ----------------
	a_accept_only_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (pend_q == '0 || (out_xfer && $onehot(pend_q))))
		else $error("byte taken while output items remain");

	a_eof_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		acc && end_of_file |=> phase_q == clutd_pkg::PH_HEADER && pos_q == '0)
		else $error("end of file did not re-arm the parser");

	a_closing_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && closing |-> pend_q[2] && pend_q[1:0] == 2'b00)
		else $error("closing status not the last item");

	a_stall_holds_items: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> pend_q == $past(pend_q))
		else $error("pending items changed under stall");

	a_pixel_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == clutd_pkg::PH_PIXELS |-> img_w_q != '0 && img_h_q != '0)
		else $error("pixel phase with empty image");

endmodule

/* rtl/core/clutd_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
module clutd_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule
